// ===== rtl/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared request and status codes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_GET          = 3'd0,
        OP_SET          = 3'd1,
        OP_INSERT       = 3'd2,
        OP_APPEND       = 3'd3,
        OP_REMOVE       = 3'd4,
        OP_REMOVE_VALUE = 3'd5,
        OP_FIND         = 3'd6,
        OP_CLEAR        = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

// ===== rtl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Fixed-capacity ordered word list with get, set, insert, append, remove,
// remove-by-value, find and clear; every request returns one response.
//
// Requests enter on s_tvalid/s_tready; responses leave on m_tvalid/m_tready.
// One request is worked at a time; the next is taken in the cycle after the
// response is registered. Set, append, clear and refused requests are answered
// from idle directly; get, insert, remove, remove_value and find first walk
// the entry store, and insert then writes its new entry at the given position.
// The walk streams one entry-store read and one write per cycle through the
// simple dual-port store. The response register frees the sequencer: a new
// request is taken while a response waits, and the sequencer holds its own
// result until the register is free. Reset empties the list; the store itself
// is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // op[2:0], position, item_value, zero padding
    input  logic [((3 + $clog2(DEPTH+1) + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // read_value, found_position, status[1:0], length, zero padding
    output logic [((VALUE_WIDTH + $clog2(DEPTH) + 2 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                 m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((VALUE_WIDTH + AW + ole_pkg::ST_W + CW + 7) / 8) * 8;

    ole_pkg::op_t           req_op;
    logic [CW-1:0]          req_pos;
    logic [VALUE_WIDTH-1:0] req_val;
    logic                   res_valid;
    logic                   res_ready;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [AW-1:0]          res_fpos;
    ole_pkg::status_t       res_status;
    logic [CW-1:0]          res_len;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;
    logic                   res_take;

    assign req_op  = ole_pkg::op_t'(s_tdata[ole_pkg::OP_W-1:0]);
    assign req_pos = s_tdata[ole_pkg::OP_W + CW - 1:ole_pkg::OP_W];
    assign req_val = s_tdata[ole_pkg::OP_W + CW + VALUE_WIDTH - 1:ole_pkg::OP_W + CW];

    ole_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (req_op),
        .req_pos    (req_pos),
        .req_val    (req_val),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value),
        .res_fpos   (res_fpos),
        .res_status (res_status),
        .res_len    (res_len),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    ole_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_vld_reg || m_tready;
    assign res_take  = res_valid && res_ready;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (res_take)
        begin
            out_vld_next  = 1'b1;
            out_data_next = OUT_W'({res_len, res_status, res_fpos, res_value});
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/ole_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ram
// Simple dual-port entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ole_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ole_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl
// Request sequencer: bounds checks, length counter and the read-modify-write
// walk over the entry store for shifts, compaction and searches.
// ----------------------------------------------------------------------------
module ole_ctrl #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ole_pkg::op_t               req_op,
    input  logic [$clog2(DEPTH+1)-1:0] req_pos,
    input  logic [VALUE_WIDTH-1:0]     req_val,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [VALUE_WIDTH-1:0]     res_value,
    output logic [$clog2(DEPTH)-1:0]   res_fpos,
    output ole_pkg::status_t           res_status,
    output logic [$clog2(DEPTH+1)-1:0] res_len,
    output logic                       ram_we,
    output logic [$clog2(DEPTH)-1:0]   ram_waddr,
    output logic [VALUE_WIDTH-1:0]     ram_wdata,
    output logic                       ram_re,
    output logic [$clog2(DEPTH)-1:0]   ram_raddr,
    input  logic [VALUE_WIDTH-1:0]     ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FINAL = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  p_vld_reg, p_vld_next;
    logic [AW-1:0]         p_addr_reg, p_addr_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic                  up_reg, up_next;
    logic [CW-1:0]         kept_reg, kept_next;
    logic                  found_reg, found_next;
    ole_pkg::op_t          op_reg, op_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] rd_reg, rd_next;
    logic [AW-1:0]         fpos_reg, fpos_next;
    ole_pkg::status_t      st_reg, st_next;
    logic [CW-1:0]         cnt_dec;
    logic                  is_full;

    assign cnt_dec = cnt_reg - CW'(1);
    assign is_full = (cnt_reg == CW'(DEPTH));

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP);
    assign res_value  = rd_reg;
    assign res_fpos   = fpos_reg;
    assign res_status = st_reg;
    assign res_len    = cnt_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        p_vld_next  = 1'b0;
        p_addr_next = p_addr_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        up_next     = up_reg;
        kept_next   = kept_reg;
        found_next  = found_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        fpos_next   = fpos_reg;
        st_next     = st_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_op;
                    pos_next   = req_pos;
                    val_next   = req_val;
                    rd_next    = '0;
                    fpos_next  = '0;
                    st_next    = ole_pkg::ST_OK;
                    found_next = 1'b0;
                    kept_next  = '0;
                    rem_next   = '0;
                    up_next    = 1'b1;
                    state_next = S_RESP;
                    unique case (req_op)
                        ole_pkg::OP_GET:
                        begin
                            if (req_pos < cnt_reg)
                            begin
                                ptr_next   = req_pos[AW-1:0];
                                rem_next   = CW'(1);
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                st_next = ole_pkg::ST_BAD_INDEX;
                            end
                        end
                        ole_pkg::OP_SET:
                        begin
                            if (req_pos < cnt_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = req_pos[AW-1:0];
                                ram_wdata = req_val;
                            end
                            else
                            begin
                                st_next = ole_pkg::ST_BAD_INDEX;
                            end
                        end
                        ole_pkg::OP_INSERT:
                        begin
                            if (req_pos > cnt_reg)
                            begin
                                st_next = ole_pkg::ST_BAD_INDEX;
                            end
                            else if (is_full)
                            begin
                                st_next = ole_pkg::ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = cnt_dec[AW-1:0];
                                rem_next   = cnt_reg - req_pos;
                                up_next    = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        ole_pkg::OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                st_next = ole_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[AW-1:0];
                                ram_wdata = req_val;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        ole_pkg::OP_REMOVE:
                        begin
                            if (req_pos < cnt_reg)
                            begin
                                ptr_next   = req_pos[AW-1:0];
                                rem_next   = cnt_reg - req_pos;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                st_next = ole_pkg::ST_BAD_INDEX;
                            end
                        end
                        ole_pkg::OP_REMOVE_VALUE,
                        ole_pkg::OP_FIND:
                        begin
                            ptr_next   = '0;
                            rem_next   = cnt_reg;
                            state_next = S_SCAN;
                        end
                        ole_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rem_reg != '0)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = ptr_reg;
                    ptr_next    = up_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                    rem_next    = rem_reg - CW'(1);
                    p_vld_next  = 1'b1;
                    p_addr_next = ptr_reg;
                end

                // data for p_addr_reg is on ram_rdata this cycle
                if (p_vld_reg)
                begin
                    unique case (op_reg)
                        ole_pkg::OP_GET:
                        begin
                            rd_next = ram_rdata;
                        end
                        ole_pkg::OP_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = p_addr_reg + AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        ole_pkg::OP_REMOVE:
                        begin
                            if (p_addr_reg == pos_reg[AW-1:0])
                            begin
                                rd_next = ram_rdata;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = p_addr_reg - AW'(1);
                                ram_wdata = ram_rdata;
                            end
                        end
                        ole_pkg::OP_REMOVE_VALUE:
                        begin
                            if (ram_rdata != val_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = kept_reg[AW-1:0];
                                ram_wdata = ram_rdata;
                                kept_next = kept_reg + CW'(1);
                            end
                        end
                        ole_pkg::OP_FIND:
                        begin
                            if (!found_reg && (ram_rdata == val_reg))
                            begin
                                found_next = 1'b1;
                                fpos_next  = p_addr_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if ((rem_reg == '0) && !p_vld_reg)
                begin
                    state_next = S_RESP;
                    unique case (op_reg)
                        ole_pkg::OP_INSERT:
                        begin
                            state_next = S_FINAL;
                        end
                        ole_pkg::OP_REMOVE:
                        begin
                            cnt_next = cnt_dec;
                        end
                        ole_pkg::OP_REMOVE_VALUE:
                        begin
                            st_next  = (kept_reg == cnt_reg) ? ole_pkg::ST_NOT_FOUND
                                                             : ole_pkg::ST_OK;
                            cnt_next = kept_reg;
                        end
                        ole_pkg::OP_FIND:
                        begin
                            st_next = found_reg ? ole_pkg::ST_OK : ole_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FINAL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            p_vld_reg <= p_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg <= p_addr_next;
        ptr_reg    <= ptr_next;
        rem_reg    <= rem_next;
        up_reg     <= up_next;
        kept_reg   <= kept_next;
        found_reg  <= found_next;
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        fpos_reg   <= fpos_next;
        st_reg     <= st_next;
    end

endmodule
